[rtl/core/aci_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aci_pkg
// Shared types and constants for the acoustic complexity index block.
// ----------------------------------------------------------------------------
package aci_pkg;

  localparam int DIV_STEPS = 32;
  localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [1:0] REG_BAND_LOW  = 2'd0;
  localparam logic [1:0] REG_BAND_HIGH = 2'd1;
  localparam logic [1:0] REG_FIRST_BIN = 2'd2;
  localparam logic [1:0] REG_BIN_COUNT = 2'd3;

  typedef struct packed {
    logic [15:0] prev;
    logic [31:0] isum;
    logic [31:0] dsum;
    logic        sat;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  bin;
    logic [31:0] isum;
    logic [31:0] dsum;
    logic        sat;
  } sum_item_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  bin;
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] quo;
    logic [31:0] dvs;
    logic        zero;
    logic        rsat;
    logic        ssat;
  } div_stage_t;

endpackage

[rtl/core/acoustic_complexity_index.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acoustic_complexity_index
// Streaming per-bin acoustic complexity index over spectrogram frames.
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// in       sink       in_valid / in_ready   magnitude, bin, first_frame, last_frame
// out      source     out_valid / out_ready out_bin, aci_value, saturated
// cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One beat enters per cycle while out is not stalled; a last-frame beat passes
// 36 register stages: 2 stages of memory read and update with forwarding, a
// 33-stage divider (an entry stage, then one quotient bit per stage), and the
// output register.
// Reset clears valid bits and loads the register defaults; the bin memory
// is not cleared; a first-frame beat overwrites every field of its bin's entry.
// A stall on out freezes the whole pipeline; in_ready drops with it.
// ----------------------------------------------------------------------------
module acoustic_complexity_index #(
  parameter int NUM_BINS = 256,
  parameter int MAG_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] magnitude,
  input  logic [7:0]  bin,
  input  logic        first_frame,
  input  logic        last_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_bin,
  output logic [31:0] aci_value,
  output logic        saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import aci_pkg::*;

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [15:0] MAG_MASK =
    (MAG_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << MAG_BITS) - 32'd1);

  logic [15:0] band_low;
  logic [15:0] band_high;
  logic [7:0]  first_bin;
  logic [8:0]  bin_count;

  logic        en;
  logic        in_window;
  sum_item_t   sums;
  logic        res_valid;
  logic [7:0]  res_bin;
  logic [31:0] res_value;
  logic        res_sat;

  // advance everything unless a finished result is held up at the output
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // window test: first_bin <= bin < first_bin + bin_count, and inside memory
  assign in_window = (bin >= first_bin) &&
                     ({2'b0, bin} < ({2'b0, first_bin} + {1'b0, bin_count})) &&
                     ({24'd0, bin} < 32'(NUM_BINS));

  always_ff @(posedge clk) begin
    if (rst) begin
      band_low  <= 16'd0;
      band_high <= 16'hFFFF;
      first_bin <= 8'd0;
      bin_count <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BAND_LOW:  band_low  <= cfg_data;
        REG_BAND_HIGH: band_high <= cfg_data;
        REG_FIRST_BIN: first_bin <= cfg_data[7:0];
        REG_BIN_COUNT: bin_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  aci_bin_state #(
    .NUM_BINS(NUM_BINS),
    .AW      (AW)
  ) u_state (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .item_valid(in_valid && in_window),
    .item_addr (AW'(bin)),
    .item_bin  (bin),
    .item_mag  (magnitude & MAG_MASK),
    .item_first(first_frame),
    .item_last (last_frame),
    .band_low  (band_low),
    .band_high (band_high),
    .result    (sums)
  );

  aci_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .sums     (sums),
    .res_valid(res_valid),
    .res_bin  (res_bin),
    .res_value(res_value),
    .res_sat  (res_sat)
  );

  // output register: load a new beat whenever the pipeline advances
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bin   <= res_bin;
      aci_value <= res_value;
      saturated <= res_sat;
    end
  end

`ifndef SYNTHESIS
  a_full_implies_sat: assert property (@(posedge clk) disable iff (rst)
    en && res_valid && res_value == SUM_MAX && !res_sat |=> out_valid && !saturated)
    else $error("output flags lost");
  a_ready_follows_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    en && res_valid && res_sat == 1'b0 && res_value == 32'd0 |=> aci_value == 32'd0)
    else $error("output register mismatch");
`endif

endmodule

[rtl/core/aci_bin_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aci_bin_state
// Per-bin memory with read, update and write stages and one-deep forwarding.
// ----------------------------------------------------------------------------
module aci_bin_state #(
  parameter int NUM_BINS = 256,
  parameter int AW       = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 item_valid,
  input  logic [AW-1:0]        item_addr,
  input  logic [7:0]           item_bin,
  input  logic [15:0]          item_mag,
  input  logic                 item_first,
  input  logic                 item_last,
  input  logic [15:0]          band_low,
  input  logic [15:0]          band_high,
  output aci_pkg::sum_item_t   result
);
  import aci_pkg::*;

  entry_t        mem [NUM_BINS];
  entry_t        rd;

  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  logic [7:0]    s1_bin;
  logic [15:0]   s1_mag;
  logic          s1_first;
  logic          s1_last;

  logic          s2_valid;
  logic [AW-1:0] s2_addr;
  logic          s2_emit;
  logic          s2_first;
  logic [7:0]    s2_bin;
  entry_t        s2_entry;

  entry_t        cur;
  entry_t        upd;

  function automatic logic in_band(input logic [15:0] v, input logic [15:0] lo,
                                   input logic [15:0] hi);
    in_band = (v > lo) && (v < hi);
  endfunction

  assign cur = (s2_valid && s2_addr == s1_addr) ? s2_entry : rd;

  always_comb begin
    logic [15:0] d;
    logic [32:0] s;
    upd      = cur;
    upd.prev = s1_mag;
    d        = (cur.prev > s1_mag) ? (cur.prev - s1_mag) : (s1_mag - cur.prev);
    s        = 33'd0;
    if (s1_first) begin
      upd.isum = 32'd0;
      upd.dsum = 32'd0;
      upd.sat  = 1'b0;
    end else if (in_band(cur.prev, band_low, band_high) &&
                 in_band(s1_mag, band_low, band_high)) begin
      s = {1'b0, cur.dsum} + {17'd0, d};
      if (s[32]) begin
        upd.dsum = SUM_MAX;
        upd.sat  = 1'b1;
      end else begin
        upd.dsum = s[31:0];
      end
    end
    if (!s1_last && in_band(s1_mag, band_low, band_high)) begin
      s = {1'b0, upd.isum} + {17'd0, s1_mag};
      if (s[32]) begin
        upd.isum = SUM_MAX;
        upd.sat  = 1'b1;
      end else begin
        upd.isum = s[31:0];
      end
    end
  end

  // memory: read on advance, write the updated entry as it leaves stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      rd <= mem[item_addr];
      if (s1_valid) begin
        mem[s1_addr] <= upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= item_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_addr  <= item_addr;
      s1_bin   <= item_bin;
      s1_mag   <= item_mag;
      s1_first <= item_first;
      s1_last  <= item_last;
      s2_addr  <= s1_addr;
      s2_bin   <= s1_bin;
      s2_emit  <= s1_last;
      s2_first <= s1_first;
      s2_entry <= upd;
    end
  end

  assign result.valid = s2_valid && s2_emit;
  assign result.bin   = s2_bin;
  assign result.isum  = s2_entry.isum;
  assign result.dsum  = s2_entry.dsum;
  assign result.sat   = s2_entry.sat;

`ifndef SYNTHESIS
  a_first_clears_diff: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_first |-> s2_entry.dsum == 32'd0)
    else $error("first frame left a difference sum");
  a_first_last_zero: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_first && s2_emit |-> s2_entry.isum == 32'd0)
    else $error("first and last frame left an intensity sum");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en && s2_valid |=> $stable(s2_entry) && s2_valid)
    else $error("stage 2 changed while stalled");
`endif

endmodule

[rtl/core/aci_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aci_divider
// Pipelined restoring divider, one quotient bit per stage, Q16.16 ratio.
// ----------------------------------------------------------------------------
module aci_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  aci_pkg::sum_item_t sums,
  output logic               res_valid,
  output logic [7:0]         res_bin,
  output logic [31:0]        res_value,
  output logic               res_sat
);
  import aci_pkg::*;

  div_stage_t st [DIV_STEPS+1];
  div_stage_t nx [DIV_STEPS];

  // entry stage: zero and overflow tests, seed remainder with the top half
  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (en) begin
      st[0].valid <= sums.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].bin  <= sums.bin;
      st[0].rem  <= {16'd0, sums.dsum[31:16]};
      st[0].num  <= {sums.dsum[15:0], 16'd0};
      st[0].quo  <= 32'd0;
      st[0].dvs  <= sums.isum;
      st[0].zero <= (sums.isum == 32'd0);
      st[0].rsat <= ({16'd0, sums.dsum[31:16]} >= sums.isum);
      st[0].ssat <= sums.sat;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    always_comb begin
      logic [32:0] t;
      t           = {st[k].rem, st[k].num[31]};
      nx[k]       = st[k];
      nx[k].num   = {st[k].num[30:0], 1'b0};
      if (t >= {1'b0, st[k].dvs}) begin
        nx[k].rem = 32'(t - {1'b0, st[k].dvs});
        nx[k].quo = {st[k].quo[30:0], 1'b1};
      end else begin
        nx[k].rem = t[31:0];
        nx[k].quo = {st[k].quo[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1].valid <= 1'b0;
      end else if (en) begin
        st[k+1].valid <= nx[k].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1].bin  <= nx[k].bin;
        st[k+1].rem  <= nx[k].rem;
        st[k+1].num  <= nx[k].num;
        st[k+1].quo  <= nx[k].quo;
        st[k+1].dvs  <= nx[k].dvs;
        st[k+1].zero <= nx[k].zero;
        st[k+1].rsat <= nx[k].rsat;
        st[k+1].ssat <= nx[k].ssat;
      end
    end
  end

  always_comb begin
    res_valid = st[DIV_STEPS].valid;
    res_bin   = st[DIV_STEPS].bin;
    if (st[DIV_STEPS].zero) begin
      res_value = 32'd0;
      res_sat   = st[DIV_STEPS].ssat;
    end else if (st[DIV_STEPS].rsat) begin
      res_value = SUM_MAX;
      res_sat   = 1'b1;
    end else begin
      res_value = st[DIV_STEPS].quo;
      res_sat   = st[DIV_STEPS].ssat;
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for acoustic_complexity_index: a built-in predictor
// tracks per-bin sums across frames and scores every result beat in order,
// under several band and window settings and random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import aci_pkg::*;

  localparam int TOTAL_ITEMS = 1750;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct packed {
    logic [7:0]  bin;
    logic [31:0] value;
    logic        sat;
  } aci_result_t;

  // Scoreboard: mirrors the per-bin state and the band/window registers, and
  // queues the index each last-frame beat must produce.
  class aci_board;
    logic [15:0] prev_mag [256];
    logic [31:0] isum [256];
    logic [31:0] dsum [256];
    bit          sum_sat [256];
    bit          opened [256];
    logic [15:0] band_low = 16'd0;
    logic [15:0] band_high = 16'hFFFF;
    logic [7:0]  first_bin = 8'd0;
    logic [8:0]  bin_count = 9'd256;
    aci_result_t pending [$];
    int          errors;
    int          results_seen;

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_BAND_LOW:  band_low = data;
        REG_BAND_HIGH: band_high = data;
        REG_FIRST_BIN: first_bin = data[7:0];
        REG_BIN_COUNT: bin_count = data[8:0];
        default: ;
      endcase
    endfunction

    function bit in_window(logic [7:0] b);
      return int'(b) >= int'(first_bin) && int'(b) < int'(first_bin) + int'(bin_count);
    endfunction

    function bit in_band(logic [15:0] v);
      return v > band_low && v < band_high;
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] d, int b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, d};
      if (s[32]) begin
        sum_sat[b] = 1'b1;
        return SUM_MAX;
      end
      return s[31:0];
    endfunction

    function void note_beat(logic [15:0] mag, logic [7:0] b, logic ff, logic lf);
      aci_result_t r;
      logic [31:0] diff;
      logic [63:0] q;
      if (!in_window(b)) return;
      if (ff) begin
        isum[b] = '0;
        dsum[b] = '0;
        sum_sat[b] = 1'b0;
        opened[b] = 1'b1;
      end else if (in_band(prev_mag[b]) && in_band(mag)) begin
        diff = (prev_mag[b] > mag) ? 32'(prev_mag[b] - mag) : 32'(mag - prev_mag[b]);
        dsum[b] = sat_add(dsum[b], diff, b);
      end
      // the final frame contributes a difference but no intensity
      if (!lf && in_band(mag)) isum[b] = sat_add(isum[b], 32'(mag), b);
      prev_mag[b] = mag;
      if (!lf) return;
      r.bin = b;
      r.sat = sum_sat[b];
      r.value = '0;
      if (isum[b] != 0) begin
        q = {dsum[b], 16'h0} / {32'h0, isum[b]};
        if (q > 64'(SUM_MAX)) begin
          q = 64'(SUM_MAX);
          r.sat = 1'b1;
        end
        r.value = q[31:0];
      end
      pending.push_back(r);
    endfunction

    function void check_beat(logic [7:0] b, logic [31:0] v, logic s);
      aci_result_t r;
      results_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result beat: out_bin %0d aci_value %0h", b, v);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (b !== r.bin) begin
        $error("out_bin: expected %0d, got %0d", r.bin, b);
        errors++;
      end
      if (v !== r.value) begin
        $error("aci_value: expected %0h, got %0h", r.value, v);
        errors++;
      end
      if (s !== r.sat) begin
        $error("saturated: expected %0b, got %0b", r.sat, s);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] magnitude = '0;
  logic [7:0]  bin = '0;
  logic        first_frame = 1'b0;
  logic        last_frame = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_bin;
  logic [31:0] aci_value;
  logic        saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  aci_board board = new();
  int       sent_items;
  int       send_idle = 32;
  int       recv_idle = 80;
  int       idle_cycles;
  int       phases_run;

  acoustic_complexity_index dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: stall at random, fresh decision every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // sample every channel on the rising edge; the watchdog counts dead cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_beat(magnitude, bin, first_frame, last_frame);
      if (out_valid && out_ready) board.check_beat(out_bin, aci_value, saturated);
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Entered and left at a falling edge; valid stays up between back-to-back beats.
  task automatic send_beat(logic [15:0] mag, logic [7:0] b, logic ff, logic lf);
    // switch idling profile by stream position: receiver-heavy, sender-heavy, none
    if (sent_items < TOTAL_ITEMS / 3) begin
      send_idle = 32;
      recv_idle = 80;
    end else if (sent_items < 2 * TOTAL_ITEMS / 3) begin
      send_idle = 80;
      recv_idle = 32;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    magnitude <= mag;
    bin <= b;
    first_frame <= ff;
    last_frame <= lf;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    @(negedge clk);
  endtask

  // Drain every expected beat, then let in-flight non-reporting beats clear.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] lo, logic [15:0] hi, logic [7:0] fb, logic [8:0] cnt);
    drain();
    write_reg(REG_BAND_LOW, lo);
    write_reg(REG_BAND_HIGH, hi);
    write_reg(REG_FIRST_BIN, 16'(fb));
    write_reg(REG_BIN_COUNT, 16'(cnt));
    phases_run++;
  endtask

  // favor band edges and the field extremes
  function automatic logic [15:0] pick_mag();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return board.band_low;
      3: return board.band_high;
      4: return board.band_low + 16'd1;
      5: return board.band_high - 16'd1;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // A well-formed analysis: a few window bins, first frame through last frame.
  task automatic run_analysis();
    int          nbins;
    int          nframes;
    int          base;
    int          lo;
    int          hi;
    logic [7:0]  b;
    lo = board.first_bin;
    hi = board.first_bin + board.bin_count - 1;
    if (hi > 255) hi = 255;
    if (hi < lo) return;
    nbins = $urandom_range(1, 6);
    nframes = $urandom_range(1, 6);
    base = $urandom_range(lo, hi);
    for (int f = 0; f < nframes; f++) begin
      for (int k = 0; k < nbins; k++) begin
        b = 8'(lo + (base - lo + k) % (hi - lo + 1));
        send_beat(pick_mag(), b, f == 0, f == nframes - 1);
      end
    end
  endtask

  // Noise: any bin and flags, but never a non-first beat on an unopened window bin.
  task automatic send_noise();
    logic [7:0] b;
    logic       ff;
    b = 8'($urandom_range(255));
    ff = $urandom_range(3) == 0;
    if (board.in_window(b) && !board.opened[b]) ff = 1'b1;
    send_beat(16'($urandom_range(65535)), b, ff, $urandom_range(2) == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset defaults first, then field extremes and paired flags
    send_beat(16'h0000, 8'd0, 1'b1, 1'b1);
    send_beat(16'hFFFF, 8'd255, 1'b1, 1'b1);
    send_beat(16'd1, 8'd0, 1'b1, 1'b0);
    send_beat(16'hFFFE, 8'd0, 1'b0, 1'b0);
    send_beat(16'd1, 8'd0, 1'b0, 1'b0);
    send_beat(16'hFFFE, 8'd0, 1'b0, 1'b1);
    send_beat(16'd1, 8'd255, 1'b1, 1'b0);
    send_beat(16'hFFFF, 8'd255, 1'b0, 1'b0);
    send_beat(16'h5555, 8'd255, 1'b0, 1'b1);
    send_beat(16'hAAAA, 8'd128, 1'b1, 1'b0);
    send_beat(16'h5555, 8'd128, 1'b0, 1'b1);
    // narrow window and band: out-of-window bins, edge magnitudes
    set_config(16'd100, 16'd200, 8'd10, 9'd4);
    send_beat(16'd150, 8'd9, 1'b1, 1'b1);
    send_beat(16'd150, 8'd14, 1'b1, 1'b1);
    send_beat(16'd100, 8'd10, 1'b1, 1'b0);
    send_beat(16'd101, 8'd10, 1'b0, 1'b0);
    send_beat(16'd199, 8'd10, 1'b0, 1'b0);
    send_beat(16'd200, 8'd10, 1'b0, 1'b1);
    send_beat(16'd150, 8'd13, 1'b1, 1'b0);
    send_beat(16'd199, 8'd13, 1'b0, 1'b1);
    // empty window ignores everything
    set_config(16'd0, 16'hFFFF, 8'd0, 9'd0);
    send_beat(16'd500, 8'd0, 1'b1, 1'b1);
    send_beat(16'd500, 8'd7, 1'b0, 1'b1);
    // window running past the top bin
    set_config(16'hFFFF, 16'h0000, 8'd255, 9'd256);
    send_beat(16'd500, 8'd255, 1'b1, 1'b1);

    // random phases, extremes of every register among them
    while (sent_items < TOTAL_ITEMS) begin
      case ($urandom_range(5))
        0: set_config(16'd0, 16'hFFFF, 8'd0, 9'd256);
        1: set_config(16'd0, 16'd0, 8'd255, 9'd1);
        2: set_config(16'hFFFF, 16'hFFFF, 8'd200, 9'd100);
        default: set_config(16'($urandom_range(30000)), 16'($urandom_range(20000, 65535)),
                            8'($urandom_range(255)), 9'($urandom_range(1, 256)));
      endcase
      repeat ($urandom_range(8, 20)) begin
        if ($urandom_range(9) < 8) run_analysis();
        else send_noise();
      end
    end

    drain();
    $display("Ran %0d input beats over %0d register settings; %0d result beats checked.",
             sent_items, phases_run, board.results_seen);
    $display("Stalls covered sender-heavy, receiver-heavy and full-rate streaming.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[acoustic_complexity_index.f]
rtl/core/aci_pkg.sv
rtl/core/aci_bin_state.sv
rtl/core/aci_divider.sv
rtl/core/acoustic_complexity_index.sv
bench/tb.sv
